// ===== hdl/md5_pkg.sv =====
`default_nettype none
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    // command passed from the front end to the compression core
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_FINAL = 2'd2
    } md5_cmd_t;

    typedef struct packed {
        md5_cmd_t   cmd;
        logic [7:0] data;
    } md5_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_RUN,
        ST_ADD,
        ST_OUT
    } md5_state_t;

    function automatic logic [31:0] step_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] step_rot(input logic [5:0] i);
        logic [4:0] r;
        unique case ({i[5:4], i[1:0]})
            4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
            4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
            4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
            4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; 4'hf: r = 5'd21;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] step_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            2'd3: g = 4'(7 * i[3:0]);
            default: g = 4'd0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/md5_hash_engine.sv =====
`default_nettype none
// MD5 engine: message bytes go in one per item through a small input queue;
// an item with last set pads the message and yields one item of four digest
// words (A..D, little-endian bytes). A byte that does not complete a 64-byte
// block is only written into the block buffer; a byte that completes one
// starts the 64 single-step compression rounds with load and feed-forward,
// and a final item adds padding at one byte per cycle (up to 64) and one or
// two compressions, then moves the digest to the output register.
// The queue of QUEUE_DEPTH items lets input arrive while the core
// compresses. A finished digest waits in its output register until popped,
// so the core can work on the next message meanwhile; a second finished
// digest waits in the core until the first one is popped.
module md5_hash_engine
    import md5_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        last,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word0,
    output logic [31:0]      digest_word1,
    output logic [31:0]      digest_word2,
    output logic [31:0]      digest_word3
);
    logic    op_valid, op_take;
    md5_op_t op;

    md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk, .rst_n, .push, .full, .data_byte, .byte_present, .last,
        .op_valid, .op, .op_take
    );

    md5_core u_core (
        .clk, .rst_n, .op_valid, .op, .op_take, .empty, .pop,
        .digest_word0, .digest_word1, .digest_word2, .digest_word3
    );
endmodule
`default_nettype wire

// ===== hdl/md5_front.sv =====
`default_nettype none
module md5_front
    import md5_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       byte_present,
    input  wire logic       last,
    output logic            op_valid,
    output md5_op_t         op,
    input  wire logic       op_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // each slot holds a byte, whether it is present and whether it ends the message
    logic [7:0]  data_mem [DEPTH];
    logic        byte_mem [DEPTH];
    logic        last_mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          part_reg;   // byte of head item already taken, final pending
    logic          accept, pop_head;

    assign full   = (cnt_reg == (AW+1)'(DEPTH));
    assign accept = push && !full && (byte_present || last);

    // classify head slot: byte first, then end of message
    always_comb
    begin
        op.data  = data_mem[rd_reg];
        op_valid = (cnt_reg != '0);
        if (byte_mem[rd_reg] && !part_reg)
            op.cmd = CMD_BYTE;
        else
            op.cmd = CMD_FINAL;
        pop_head = op_valid && op_take &&
                   (op.cmd == CMD_FINAL || !last_mem[rd_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_mem[wr_reg] <= data_byte;
            byte_mem[wr_reg] <= byte_present;
            last_mem[wr_reg] <= last;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            part_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop_head)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(accept) - (AW+1)'(pop_head);
            if (pop_head)
                part_reg <= 1'b0;
            else if (op_valid && op_take)
                part_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/md5_core.sv =====
`default_nettype none
module md5_core
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        op_valid,
    input  md5_op_t          op,
    output logic             op_take,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      digest_word0,
    output logic [31:0]      digest_word1,
    output logic [31:0]      digest_word2,
    output logic [31:0]      digest_word3
);
    md5_state_t state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] ch_reg [4];
    logic [31:0] dig_reg [4];
    logic        dig_valid_reg;
    logic        out_free;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [60:0] total_reg;
    logic [5:0]  pos_reg;      // fill position while padding
    logic [5:0]  step_reg;
    logic        fin_reg;      // block being compressed belongs to the padded end of the message
    logic        more_reg;     // another block follows (pad overflow)
    logic [31:0] f, sum, rot, mw;
    logic [63:0] bits;
    logic [4:0]  sh;

    assign bits = {total_reg, 3'b000};

    // output register can take a new digest
    assign out_free = !dig_valid_reg || pop;

    // one MD5 step per cycle
    always_comb
    begin
        unique case (step_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        mw  = blk_reg[step_g(step_reg)];
        sum = a_reg + f + step_k(step_reg) + mw;
        sh  = step_rot(step_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (op_valid)
                begin
                    if (op.cmd == CMD_BYTE)
                        state_next = (total_reg[5:0] == 6'd63) ? ST_RUN : ST_IDLE;
                    else
                        state_next = ST_PAD;
                end
            ST_PAD:  state_next = (pos_reg == 6'd63) ? ST_RUN : ST_ZERO;
            ST_ZERO:
                if (pos_reg == 6'd63 || (!more_reg && pos_reg == LEN_POS - 6'd1))
                    state_next = more_reg ? ST_RUN : ST_LEN;
            ST_LEN:  state_next = ST_RUN;
            ST_RUN:  state_next = (step_reg == 6'd63) ? ST_ADD : ST_RUN;
            ST_ADD:
                if (fin_reg && !more_reg)
                    state_next = ST_OUT;
                else if (more_reg)
                    state_next = ST_ZERO;
                else
                    state_next = ST_IDLE;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op_take = (state_reg == ST_IDLE) && op_valid;
        empty   = !dig_valid_reg;
        digest_word0 = dig_reg[0];
        digest_word1 = dig_reg[1];
        digest_word2 = dig_reg[2];
        digest_word3 = dig_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // hold the finished digest until popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_valid_reg <= 1'b0;
            dig_reg[0]    <= '0;
            dig_reg[1]    <= '0;
            dig_reg[2]    <= '0;
            dig_reg[3]    <= '0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            dig_valid_reg <= 1'b1;
            dig_reg[0]    <= ch_reg[0];
            dig_reg[1]    <= ch_reg[1];
            dig_reg[2]    <= ch_reg[2];
            dig_reg[3]    <= ch_reg[3];
        end
        else if (pop)
            dig_valid_reg <= 1'b0;
    end

    // block words, padding and compression datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg[0] <= INIT_A;
            ch_reg[1] <= INIT_B;
            ch_reg[2] <= INIT_C;
            ch_reg[3] <= INIT_D;
            total_reg <= '0;
            fin_reg   <= 1'b0;
            more_reg  <= 1'b0;
            pos_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (op_valid)
                    begin
                        if (op.cmd == CMD_BYTE)
                        begin
                            if (total_reg[1:0] == 2'd0)
                                blk_reg[total_reg[5:2]] <= {24'd0, op.data};
                            else
                                blk_reg[total_reg[5:2]][total_reg[1:0]*8 +: 8] <= op.data;
                            total_reg <= total_reg + 61'd1;
                            fin_reg   <= 1'b0;
                        end
                        else
                        begin
                            pos_reg  <= total_reg[5:0];
                            more_reg <= (total_reg[5:0] >= LEN_POS);
                            fin_reg  <= 1'b1;
                        end
                    end
                ST_PAD:
                begin
                    if (pos_reg[1:0] == 2'd0)
                        blk_reg[pos_reg[5:2]] <= {24'd0, PAD_BYTE};
                    else
                        blk_reg[pos_reg[5:2]][pos_reg[1:0]*8 +: 8] <= PAD_BYTE;
                    pos_reg <= pos_reg + 6'd1;
                end
                ST_ZERO:
                begin
                    if (pos_reg[1:0] == 2'd0)
                        blk_reg[pos_reg[5:2]] <= '0;
                    else
                        blk_reg[pos_reg[5:2]][pos_reg[1:0]*8 +: 8] <= 8'd0;
                    pos_reg <= pos_reg + 6'd1;
                end
                ST_LEN:
                begin
                    blk_reg[14] <= bits[31:0];
                    blk_reg[15] <= bits[63:32];
                end
                ST_RUN:
                begin
                    a_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= b_reg;
                    b_reg <= b_reg + rot;
                    step_reg <= step_reg + 6'd1;
                end
                ST_ADD:
                begin
                    ch_reg[0] <= ch_reg[0] + a_reg;
                    ch_reg[1] <= ch_reg[1] + b_reg;
                    ch_reg[2] <= ch_reg[2] + c_reg;
                    ch_reg[3] <= ch_reg[3] + d_reg;
                    more_reg  <= 1'b0;
                    pos_reg   <= '0;
                end
                ST_OUT:
                    if (out_free)
                    begin
                        ch_reg[0] <= INIT_A;
                        ch_reg[1] <= INIT_B;
                        ch_reg[2] <= INIT_C;
                        ch_reg[3] <= INIT_D;
                        total_reg <= '0;
                        fin_reg   <= 1'b0;
                    end
                default: ;
            endcase
            // load working words on entry to compression
            if (state_next == ST_RUN && state_reg != ST_RUN)
            begin
                a_reg    <= ch_reg[0];
                b_reg    <= ch_reg[1];
                c_reg    <= ch_reg[2];
                d_reg    <= ch_reg[3];
                step_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire
